// ===== design/lzd_pkg.sv =====
package lzd_pkg;

  localparam int WIN_AW     = 12;
  localparam int LEN_W      = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [3:0] RLE_NIBBLE  = 4'hF;
  localparam logic [8:0] MIN_MATCH   = 9'd3;
  localparam logic [8:0] LONG_RUN    = 9'd19;
  localparam logic [11:0] BASE_RESET = 12'd18;

  localparam logic CFG_RLE_ENABLE  = 1'b0;
  localparam logic CFG_WINDOW_BASE = 1'b1;

  localparam logic [1:0] CMD_PRELOAD = 2'd0;
  localparam logic [1:0] CMD_RUN     = 2'd1;
  localparam logic [1:0] CMD_COPY    = 2'd2;
  localparam logic [1:0] CMD_END     = 2'd3;

  typedef struct packed {
    logic        action;
    logic [11:0] window_index;
    logic [7:0]  byte_value;
    logic        last_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        token_done;
    logic        stream_done;
    logic        truncated;
  } out_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WIN_AW-1:0] addr;
    logic [7:0]        value;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              trunc;
  } cmd_t;

endpackage

// ===== design/lzd_ram.sv =====
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lzd_fifo.sv =====
module lzd_fifo import lzd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push && !full) - (FIFO_AW+1)'(pop && !empty);
    end
  end

endmodule

// ===== design/lzd_front.sv =====
module lzd_front import lzd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        full
);

  logic        rle_enable;
  logic [11:0] window_base;
  logic [7:0]  flag_bits;
  logic [3:0]  flags_left;
  logic [1:0]  token_phase;
  logic [7:0]  first_byte;

  logic [7:0]  flag_bits_next;
  logic [3:0]  flags_left_next;
  logic [1:0]  token_phase_next;
  logic [7:0]  first_byte_next;
  logic        accept;
  logic        done;
  logic [7:0]  b;
  logic [3:0]  lo;
  logic [3:0]  hi;

  assign in_ready  = !full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign b         = in_data.byte_value;
  assign lo        = b[3:0];
  assign hi        = b[7:4];

  always_comb begin
    flag_bits_next   = flag_bits;
    flags_left_next  = flags_left;
    token_phase_next = token_phase;
    first_byte_next  = first_byte;
    done             = 1'b0;
    push             = 1'b0;
    push_cmd.kind    = CMD_RUN;
    push_cmd.addr    = in_data.window_index;
    push_cmd.value   = b;
    push_cmd.len     = 9'd1;
    push_cmd.last    = in_data.last_byte;
    push_cmd.trunc   = 1'b0;
    if (accept) begin
      if (!in_data.action) begin
        push          = 1'b1;
        push_cmd.kind = CMD_PRELOAD;
        push_cmd.last = 1'b0;
      end else if (flags_left == '0) begin
        flag_bits_next   = b;
        flags_left_next  = 4'd8;
        token_phase_next = 2'd0;
        if (in_data.last_byte) begin
          push          = 1'b1;
          push_cmd.kind = CMD_END;
        end
      end else if (token_phase == 2'd0 && flag_bits[0]) begin
        push = 1'b1;
        done = 1'b1;
      end else if (token_phase == 2'd0) begin
        first_byte_next  = b;
        token_phase_next = 2'd1;
        if (in_data.last_byte) begin
          push           = 1'b1;
          push_cmd.kind  = CMD_END;
          push_cmd.trunc = 1'b1;
        end
      end else if (token_phase == 2'd1) begin
        if (rle_enable && lo == RLE_NIBBLE) begin
          if (hi == '0) begin
            token_phase_next = 2'd2;
            if (in_data.last_byte) begin
              push           = 1'b1;
              push_cmd.kind  = CMD_END;
              push_cmd.trunc = 1'b1;
            end
          end else begin
            push           = 1'b1;
            done           = 1'b1;
            push_cmd.value = first_byte;
            push_cmd.len   = LEN_W'(hi) + MIN_MATCH;
          end
        end else begin
          push          = 1'b1;
          done          = 1'b1;
          push_cmd.kind = CMD_COPY;
          push_cmd.addr = {hi, first_byte} + window_base;
          push_cmd.len  = LEN_W'(lo) + MIN_MATCH;
        end
      end else begin
        push         = 1'b1;
        done         = 1'b1;
        push_cmd.len = LEN_W'(first_byte) + LONG_RUN;
      end
      if (done) begin
        flag_bits_next   = flag_bits >> 1;
        flags_left_next  = flags_left - 1'b1;
        token_phase_next = 2'd0;
      end
      if (in_data.action && in_data.last_byte) begin
        flag_bits_next   = '0;
        flags_left_next  = '0;
        token_phase_next = 2'd0;
        first_byte_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_enable  <= 1'b0;
      window_base <= BASE_RESET;
      flag_bits   <= '0;
      flags_left  <= '0;
      token_phase <= '0;
      first_byte  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RLE_ENABLE:  rle_enable  <= cfg_data[0];
          CFG_WINDOW_BASE: window_base <= cfg_data;
          default: ;
        endcase
      end
      flag_bits   <= flag_bits_next;
      flags_left  <= flags_left_next;
      token_phase <= token_phase_next;
      first_byte  <= first_byte_next;
    end
  end

endmodule

// ===== design/lzd_back.sv =====
module lzd_back import lzd_pkg::*; #(
  parameter int OUT_LANES = 8
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t head,
  input  logic empty,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_CRD  = 2'd2;
  localparam logic [1:0] ST_CWR  = 2'd3;

  logic [1:0]        state;
  logic [7:0]        value;
  logic [LEN_W-1:0]  len;
  logic [WIN_AW-1:0] src;
  logic              is_last;
  logic [WIN_AW-1:0] wp;
  logic [63:0]       acc;
  logic [2:0]        lanes;

  logic              out_free;
  logic              stepping;
  logic              final_byte;
  logic              emit;
  logic              go;
  logic              load_out;
  logic [7:0]        cur;
  logic [7:0]        rdata;
  logic              we;
  logic [WIN_AW-1:0] waddr;
  logic [7:0]        wdata;
  logic [63:0]       word;

  assign out_free   = !out_valid || out_ready;
  assign stepping   = (state == ST_RUN) || (state == ST_CWR);
  assign final_byte = (len == LEN_W'(1));
  assign emit       = (lanes == 3'(OUT_LANES - 1)) || final_byte;
  assign go         = stepping && (!emit || out_free);
  assign cur        = (state == ST_CWR) ? rdata : value;
  assign pop        = (state == ST_IDLE) && !empty && (head.kind != CMD_END || out_free);
  assign load_out   = (pop && head.kind == CMD_END) || (go && emit);

  always_comb begin
    word = acc;
    word[lanes*8 +: 8] = cur;
  end

  always_comb begin
    we    = go;
    waddr = wp;
    wdata = cur;
    if (pop && head.kind == CMD_PRELOAD) begin
      we    = 1'b1;
      waddr = head.addr;
      wdata = head.value;
    end
  end

  lzd_ram #(.WIDTH(8), .DEPTH(1 << WIN_AW)) u_window (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (src),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      lanes     <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            value   <= head.value;
            len     <= head.len;
            src     <= head.addr;
            is_last <= head.last;
            case (head.kind)
              CMD_RUN:  state <= ST_RUN;
              CMD_COPY: state <= ST_CRD;
              CMD_END: begin
                out_valid            <= 1'b1;
                out_data.out_bytes   <= '0;
                out_data.byte_count  <= '0;
                out_data.token_done  <= 1'b0;
                out_data.stream_done <= 1'b1;
                out_data.truncated   <= head.trunc;
                wp                   <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_CRD: state <= ST_CWR;
        ST_RUN, ST_CWR: begin
          if (go) begin
            wp  <= (final_byte && is_last) ? '0 : wp + 1'b1;
            len <= len - 1'b1;
            src <= src + 1'b1;
            if (emit) begin
              out_valid            <= 1'b1;
              out_data.out_bytes   <= word;
              out_data.byte_count  <= 4'(lanes) + 4'd1;
              out_data.token_done  <= final_byte;
              out_data.stream_done <= final_byte && is_last;
              out_data.truncated   <= 1'b0;
              acc                  <= '0;
              lanes                <= '0;
            end else begin
              acc   <= word;
              lanes <= lanes + 1'b1;
            end
            if (final_byte) begin
              state <= ST_IDLE;
            end else if (state == ST_CWR) begin
              state <= ST_CRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lzss_ring_rle_decoder_unit.sv =====
// LZSS decoder with a 4096-byte ring window and an optional run-length mode.
// Input beats on in_valid/in_ready either preload a window byte (action 0) or
// carry one compressed stream byte (action 1, last_byte on the final one).
// Result beats on out_valid/out_ready carry up to OUT_LANES decoded bytes,
// first byte in the lowest lane, with token and stream end marks.
// Configuration beats on cfg_valid/cfg_ready write rle_enable (index 0) or
// window_base (index 1); they are always taken and belong to idle periods.
// The front end classifies each byte combinationally and queues at most one
// command for it; the back end works off the queue, handling a preload or end
// marker as it pops it, a literal or run one output byte per step, and a copy
// one byte per read step and write step, because every byte goes through the
// registered read port of the window RAM. A result is visible in the cycle
// after its last byte is produced. Input throughput follows the expansion:
// with the queue full, input waits until the back end frees a slot. A stalled
// receiver holds the output register, and the back end waits whenever it has
// another word to hand over. Reset clears the parser, queue, write pointer and
// configuration; window contents are undefined until preloaded or decoded.
module lzss_ring_rle_decoder_unit import lzd_pkg::*; #(
  parameter int OUT_LANES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t head;
  logic empty;

  lzd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  lzd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  lzd_back #(.OUT_LANES(OUT_LANES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/lzss_ring_rle_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module lzss_ring_rle_decoder_unit_test;
  import lzd_pkg::*;

  localparam int  LIMIT_CYCLES = 2000000;
  localparam int  SETTLE_CYCLES = 700;
  localparam int  WINDOW_SIZE_C = 4096;
  localparam int  PRELOAD_SPAN = 64;
  localparam int  COPY_SPAN = PRELOAD_SPAN - 18;
  localparam logic ACT_PRELOAD = 1'b0;
  localparam logic ACT_STREAM  = 1'b1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [11:0] cfg_data;

  lzss_ring_rle_decoder_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the decoder state.
  logic [7:0]  win_mem [WINDOW_SIZE_C];
  logic [11:0] wr_ptr;
  logic [7:0]  flag_reg;
  int          flags_rem;
  int          tok_phase;
  logic [7:0]  tok_b0;
  logic        rle_on;
  logic [11:0] base_off;
  logic [63:0] pack_word;
  int          pack_lanes;
  int          step_base;

  out_t expected_words [$];
  logic pin_on;
  out_t pin_word;

  int   cycles = 0;
  int   mismatches = 0;
  int   words_seen = 0;
  int   stream_beats = 0;
  int   streams_sent = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   hold_left = 0;

  task automatic push_word(logic [63:0] w, int cnt, logic td, logic sd, logic tr);
    out_t r;
    r.out_bytes = w;
    r.byte_count = cnt[3:0];
    r.token_done = td;
    r.stream_done = sd;
    r.truncated = tr;
    expected_words.insert(expected_words.size(), r);
  endtask

  task automatic emit_byte(logic [7:0] b);
    win_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 12'd1;
    pack_word = pack_word | (64'(b) << (8 * pack_lanes));
    pack_lanes++;
    if (pack_lanes >= 8) begin
      push_word(pack_word, pack_lanes, 1'b0, 1'b0, 1'b0);
      pack_word = '0;
      pack_lanes = 0;
    end
  endtask

  task automatic close_token(logic last);
    int n;
    if (pack_lanes > 0) begin
      push_word(pack_word, pack_lanes, 1'b0, 1'b0, 1'b0);
      pack_word = '0;
      pack_lanes = 0;
    end
    n = expected_words.size();
    if (n > step_base) begin
      expected_words[n-1].token_done = 1'b1;
      expected_words[n-1].stream_done = last;
    end
  endtask

  task automatic clear_stream();
    wr_ptr = '0;
    flag_reg = '0;
    flags_rem = 0;
    tok_phase = 0;
    tok_b0 = '0;
  endtask

  task automatic decode_beat(in_t it);
    logic        done;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [11:0] src;
    int          len;
    done = 1'b0;
    step_base = expected_words.size();
    pack_word = '0;
    pack_lanes = 0;
    lo = it.byte_value[3:0];
    hi = it.byte_value[7:4];
    if (it.action == ACT_PRELOAD) begin
      win_mem[it.window_index] = it.byte_value;
    end else if (flags_rem == 0) begin
      flag_reg = it.byte_value;
      flags_rem = 8;
      tok_phase = 0;
      if (it.last_byte) begin
        push_word('0, 0, 1'b0, 1'b1, 1'b0);
        clear_stream();
      end
    end else begin
      if (tok_phase == 0 && flag_reg[0]) begin
        emit_byte(it.byte_value);
        done = 1'b1;
      end else if (tok_phase == 0) begin
        tok_b0 = it.byte_value;
        tok_phase = 1;
      end else if (tok_phase == 1) begin
        if (rle_on && lo == RLE_NIBBLE) begin
          if (hi == 4'd0) begin
            tok_phase = 2;
          end else begin
            for (int i = 0; i < int'(hi) + 3; i++) emit_byte(tok_b0);
            done = 1'b1;
          end
        end else begin
          src = {hi, tok_b0} + base_off;
          len = int'(lo) + 3;
          // Byte by byte, so a source just behind the write pointer repeats.
          for (int i = 0; i < len; i++) begin
            emit_byte(win_mem[src]);
            src = src + 12'd1;
          end
          done = 1'b1;
        end
      end else begin
        for (int i = 0; i < int'(tok_b0) + 19; i++) emit_byte(it.byte_value);
        done = 1'b1;
      end
      if (done) begin
        close_token(it.last_byte);
        flag_reg = flag_reg >> 1;
        flags_rem--;
        tok_phase = 0;
        if (it.last_byte) clear_stream();
      end else if (it.last_byte) begin
        push_word('0, 0, 1'b0, 1'b1, 1'b1);
        clear_stream();
      end
    end
    if (pin_on && it.action == ACT_STREAM) begin
      while (expected_words.size() > step_base)
        expected_words.delete(expected_words.size() - 1);
      expected_words.insert(expected_words.size(), pin_word);
    end
  endtask

  // Checker and cycle limit.
  always @(posedge clk) begin
    out_t w;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_words.size());
      $display("** lzss_ring_rle_decoder_unit: FAILED **");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_data);
        end else begin
          w = expected_words.pop_front();
          if (out_data.out_bytes !== w.out_bytes || out_data.byte_count !== w.byte_count ||
              out_data.token_done !== w.token_done ||
              out_data.stream_done !== w.stream_done ||
              out_data.truncated !== w.truncated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp bytes %h cnt %0d td %b sd %b tr %b, got %h %0d %b %b %b",
                       w.out_bytes, w.byte_count, w.token_done, w.stream_done,
                       w.truncated, out_data.out_bytes, out_data.byte_count,
                       out_data.token_done, out_data.stream_done, out_data.truncated);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RLE_ENABLE) rle_on = cfg_data[0];
        else base_off = cfg_data;
      end
      if (in_valid && in_ready) decode_beat(in_data);
    end
  end

  // Result side backpressure, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_beat(in_t it, logic pin, out_t pw);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    pin_on <= pin;
    pin_word <= pw;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (it.action == ACT_STREAM) stream_beats++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_words.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_t mk_in(logic a, logic [11:0] idx, logic [7:0] b, logic l);
    in_t it;
    it.action = a;
    it.window_index = idx;
    it.byte_value = b;
    it.last_byte = l;
    return it;
  endfunction

  function automatic out_t mk_out(logic sd, logic tr);
    out_t r;
    r = '0;
    r.stream_done = sd;
    r.truncated = tr;
    return r;
  endfunction

  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [11:0] cfg_val;
    in_t         it;
    bit          pinned;
    out_t        res;
  } row_t;

  row_t plan [$];

  function automatic row_t row_in(logic [7:0] b, logic l);
    row_t r;
    r = '{default: '0};
    r.it = mk_in(ACT_STREAM, 12'd0, b, l);
    return r;
  endfunction

  function automatic row_t row_pin(logic [7:0] b, logic tr);
    row_t r;
    r = row_in(b, 1'b1);
    r.pinned = 1'b1;
    r.res = mk_out(1'b1, tr);
    return r;
  endfunction

  function automatic row_t row_cfg(logic idx, logic [11:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic add_row(row_t r);
    plan.insert(plan.size(), r);
  endtask

  task automatic send_stream(int tokens, int end_mode);
    logic [7:0]  bytes [$];
    logic [7:0]  flag;
    logic [7:0]  b1;
    logic [11:0] pos;
    int          made;
    bit          stop;
    in_t         it;
    made = 0;
    stop = 1'b0;
    while (!stop) begin
      flag = 8'($urandom);
      bytes.insert(bytes.size(), flag);
      if (made >= tokens && end_mode == 1) break;
      for (int i = 0; i < 8 && !stop; i++) begin
        if (made + 1 >= tokens && end_mode == 2 && !flag[i]) begin
          // Cut the stream inside a token.
          bytes.insert(bytes.size(), 8'($urandom_range(0, 15)));
          if (rle_on && $urandom_range(1)) bytes.insert(bytes.size(), 8'h0F);
          stop = 1'b1;
        end else if (flag[i]) begin
          bytes.insert(bytes.size(), 8'($urandom));
        end else begin
          if (rle_on && $urandom_range(3) == 0) begin
            bytes.insert(bytes.size(),
                         ($urandom_range(30) == 0) ? 8'hFF : 8'($urandom_range(0, 12)));
            bytes.insert(bytes.size(), 8'h0F);
            bytes.insert(bytes.size(), 8'($urandom));
          end else begin
            // Copies read only from the preloaded low part of the window.
            pos = 12'($urandom_range(0, COPY_SPAN)) - base_off;
            b1 = {pos[11:8], 4'($urandom)};
            bytes.insert(bytes.size(), pos[7:0]);
            bytes.insert(bytes.size(), b1);
          end
        end
        if (!stop) begin
          made++;
          if (made >= tokens && end_mode != 1) stop = 1'b1;
        end
      end
    end
    foreach (bytes[k]) begin
      if ($urandom_range(9) == 0)
        send_beat(mk_in(ACT_PRELOAD, 12'($urandom), 8'($urandom), 1'($urandom)),
                  1'b0, '0);
      send_beat(mk_in(ACT_STREAM, 12'($urandom), bytes[k], k == bytes.size() - 1),
                1'b0, '0);
    end
    streams_sent++;
  endtask

  initial begin
    logic        cfg_rle [6];
    logic [11:0] cfg_base [6];
    int          target;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    pin_on = 1'b0;
    pin_word = '0;
    rle_on = 1'b0;
    base_off = BASE_RESET;
    clear_stream();
    for (int i = 0; i < WINDOW_SIZE_C; i++) win_mem[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the low part of the window; every copy reads from there or from
    // bytes that the decoder has already written.
    for (int i = 0; i < PRELOAD_SPAN; i++)
      send_beat(mk_in(ACT_PRELOAD, 12'(i), 8'($urandom), 1'b0), 1'b0, '0);

    add_row(row_pin(8'h00, 1'b0));
    add_row(row_in(8'hFF, 1'b0));
    add_row(row_in(8'h00, 1'b0));
    add_row(row_in(8'hFF, 1'b1));
    add_row(row_in(8'h03, 1'b0));
    add_row(row_in(8'h00, 1'b0));
    add_row(row_in(8'hFF, 1'b0));
    add_row(row_in(8'hEF, 1'b0));
    add_row(row_in(8'hF5, 1'b0));
    add_row(row_in(8'hFF, 1'b0));
    add_row(row_in(8'hFF, 1'b0));
    add_row(row_in(8'h00, 1'b0));
    add_row(row_in(8'h00, 1'b0));
    add_row(row_pin(8'h12, 1'b1));
    add_row(row_cfg(CFG_RLE_ENABLE, 12'd1));
    add_row(row_cfg(CFG_WINDOW_BASE, 12'd17));
    add_row(row_in(8'h00, 1'b0));
    add_row(row_in(8'h5A, 1'b0));
    add_row(row_in(8'hFF, 1'b0));
    add_row(row_in(8'hFF, 1'b0));
    add_row(row_in(8'h0F, 1'b0));
    add_row(row_in(8'h01, 1'b0));
    add_row(row_in(8'h00, 1'b0));
    add_row(row_in(8'h1E, 1'b0));
    add_row(row_in(8'h07, 1'b0));
    add_row(row_pin(8'h0F, 1'b1));
    // A preload inside a stream must not disturb it, even with last set.
    plan[2].it = mk_in(ACT_PRELOAD, 12'hFFF, 8'hFF, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_beat(plan[i].it, plan[i].pinned, plan[i].res);
      end
    end
    drain();

    cfg_rle = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    cfg_base = '{12'd18, 12'd17, 12'd0, 12'd4095, 12'd4095, 12'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_RLE_ENABLE, {11'd0, cfg_rle[p]});
      write_reg(CFG_WINDOW_BASE, cfg_base[p]);
      in_idle_pct = (p < 2) ? 38 : (p < 4) ? 79 : 0;
      out_idle_pct = (p < 2) ? 79 : (p < 4) ? 38 : 0;
      if (p == 4) hold_left = 400;
      target = stream_beats + 36;
      while (stream_beats < target) begin
        int mode;
        mode = $urandom_range(7);
        send_stream($urandom_range(1, 12), (mode == 0) ? 1 : (mode == 1) ? 2 : 0);
      end
      // Sender waits here until every expected word has come back.
      drain();
    end

    $display("covered %0d streams, %0d stream beats, %0d result words, 6 settings",
             streams_sent, stream_beats, words_seen);
    if (mismatches == 0) begin
      $display("** lzss_ring_rle_decoder_unit: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** lzss_ring_rle_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lzd_pkg.sv
design/lzd_ram.sv
design/lzd_fifo.sv
design/lzd_front.sv
design/lzd_back.sv
design/lzss_ring_rle_decoder_unit.sv
tb/lzss_ring_rle_decoder_unit_test.sv
